// ----- design/ptrm_pkg.sv -----
`default_nettype none

package ptrm_pkg;

    // Field widths fixed by the interface
    localparam int DATA_W      = 32;
    localparam int OP_W        = 2;
    localparam int KIND_W      = 3;
    localparam int TIDX_W      = 4;
    localparam int LIMIT_W     = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_TDATA_W  = 5 * DATA_W;
    localparam int OUT_FIELD_W = 1 + TIDX_W + 3 * DATA_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    // Defaults for the top-level parameters
    localparam int MAX_TASKS_DEF = 16;
    localparam int TIME_BITS_DEF = 32;

    // Configuration register reset values
    localparam logic [LIMIT_W-1:0] TASK_LIMIT_RST = 5'd16;
    localparam logic [DATA_W-1:0]  DEFAULT_WC_RST = 32'd1000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TASK_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_WC = 1'b1;

    // Input opcodes
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
    localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD     = 3'd0,
        KIND_RELEASE = 3'd1,
        KIND_DONE    = 3'd2,
        KIND_REPORT  = 3'd3,
        KIND_BUSY    = 3'd4,
        KIND_HALTED  = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               accepted;
        logic [TIDX_W-1:0]  task_index;
        logic [DATA_W-1:0]  offset_wait;
        logic [DATA_W-1:0]  last_exec;
        logic [DATA_W-1:0]  worst_exec;
        logic               last_of_run;
    } t_result;

    // Shared subtract/compare unit result
    typedef struct packed {
        logic [DATA_W-1:0] diff;
        logic              lt;
    } t_alu_out;

endpackage

`default_nettype wire

// ----- design/ptrm_ram.sv -----
`default_nettype none

module ptrm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic                                    i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/ptrm_alu.sv -----
`default_nettype none

module ptrm_alu
    import ptrm_pkg::*;
(
    input  wire logic [DATA_W-1:0] i_a,
    input  wire logic [DATA_W-1:0] i_b,
    output t_alu_out               o_res
);

    logic [DATA_W:0] w_sub;

    // One subtractor: the borrow out doubles as the a < b flag
    assign w_sub       = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.diff  = w_sub[DATA_W-1:0];
    assign o_res.lt    = w_sub[DATA_W];

endmodule

`default_nettype wire

// ----- design/periodic_task_release_monitor_core.sv -----
`default_nettype none

// Periodic task release monitor.
// Slave stream (s): one transaction per command. tuser carries the opcode (add, tick,
// report); tdata carries period, offset, best case, worst case and measured time.
// Master stream (m): answers. tuser is the answer kind, tlast marks the final answer of
// a command. A passing report gives two answers: the report answer, then the next
// release or walk done.
// Config channel: index 0 is the task limit, index 1 the default worst case; write only
// while the block is idle. cfg_ready is always high.
// Flow: one command at a time; s_tready is high only in the idle state.
//   halted, busy: straight to the emit state; add: the add state, then the emit state.
//   tick: a read and a check state per entry not due, a release state for a due
//   entry, then the emit state. The entry table has one read and one write port;
//   the add check, all decrements and the report compares use one shared subtractor.
//   report: read, max, low and high check states, then the answer; a passing report
//   then resumes the walk as for a tick.
// The output register holds an answer until taken; a stalled receiver holds the
// sequencer only when a further answer is ready.
// Reset clears the task count, walk position, report and halt flags, and loads the
// configuration registers with their reset values; table entries are written before they are read.
module periodic_task_release_monitor_core
    import ptrm_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // tdata: period_ticks, offset_us, best_case_us, worst_case_us, measured_us
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    // tuser: opcode
    input  wire logic [OP_W-1:0]        i_s_tuser,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    // tdata: accepted, task_index, offset_wait_us, last_exec_us, worst_exec_us, pad
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    // tuser: kind
    output logic [KIND_W-1:0]           o_m_tuser,
    output logic                        o_m_tlast,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [DATA_W-1:0]      i_cfg_data
);

    localparam int SW     = TIME_BITS < DATA_W ? TIME_BITS : DATA_W;
    localparam int IDX_W  = MAX_TASKS > 1 ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int CMP_W  = CNT_W > LIMIT_W ? CNT_W : LIMIT_W;

    typedef struct packed {
        logic [DATA_W-1:0] period;
        logic [DATA_W-1:0] countdown;
        logic [SW-1:0]     offset;
        logic [SW-1:0]     best;
        logic [SW-1:0]     worst;
        logic [SW-1:0]     last_t;
        logic [SW-1:0]     max_t;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_ADD      = 10'b00_0000_0010,
        S_WALK_RD  = 10'b00_0000_0100,
        S_WALK_CHK = 10'b00_0000_1000,
        S_WALK_REL = 10'b00_0001_0000,
        S_REP_RD   = 10'b00_0010_0000,
        S_REP_MAX  = 10'b00_0100_0000,
        S_REP_LO   = 10'b00_1000_0000,
        S_REP_HI   = 10'b01_0000_0000,
        S_EMIT     = 10'b10_0000_0000
    } t_state;

    // Control registers
    t_state             r_state,    n_state;
    logic [CNT_W-1:0]   r_task_cnt, n_task_cnt;
    logic [CNT_W-1:0]   r_walk_pos, n_walk_pos;
    logic               r_await,    n_await;
    logic               r_halted,   n_halted;
    logic               r_cont,     n_cont;
    logic               r_ovalid,   n_ovalid;
    logic [LIMIT_W-1:0] r_task_limit;
    logic [DATA_W-1:0]  r_default_wc;

    // Payload registers
    logic [DATA_W-1:0]  r_period,  n_period;
    logic [SW-1:0]      r_offset,  n_offset;
    logic [SW-1:0]      r_best,    n_best;
    logic [SW-1:0]      r_worst,   n_worst;
    logic [SW-1:0]      r_meas,    n_meas;
    logic [SW-1:0]      r_new_max, n_new_max;
    logic               r_fail,    n_fail;
    t_result            r_res,     n_res;
    t_result            r_out,     n_out;

    // Table and shared unit
    logic               w_we, w_re;
    logic [IDX_W-1:0]   w_waddr, w_raddr;
    t_entry             w_wentry, w_rentry;
    logic [ENTRY_W-1:0] w_rdata;
    logic [DATA_W-1:0]  w_alu_a, w_alu_b;
    t_alu_out           w_alu;

    logic [DATA_W-1:0]  w_in_period, w_in_offset, w_in_best, w_in_worst, w_in_meas;
    logic               w_s_acc, w_out_free, w_full;

    assign w_in_period = i_s_tdata[DATA_W-1:0];
    assign w_in_offset = i_s_tdata[2*DATA_W-1:DATA_W];
    assign w_in_best   = i_s_tdata[3*DATA_W-1:2*DATA_W];
    assign w_in_worst  = i_s_tdata[4*DATA_W-1:3*DATA_W];
    assign w_in_meas   = i_s_tdata[5*DATA_W-1:4*DATA_W];

    assign o_s_tready  = (r_state == S_IDLE);
    assign w_s_acc     = i_s_tvalid && o_s_tready;
    assign w_out_free  = !r_ovalid || i_m_tready;
    assign o_cfg_ready = 1'b1;

    assign w_full = (CMP_W'(r_task_cnt) >= CMP_W'(r_task_limit)) ||
                    (r_task_cnt >= CNT_W'(MAX_TASKS));

    assign w_rentry = t_entry'(w_rdata);

    ptrm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wentry),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ptrm_alu u_alu (
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .o_res (w_alu)
    );

    // Operand selection for the shared subtractor
    always_comb begin
        w_alu_a = '0;
        w_alu_b = '0;
        unique case (r_state)
            S_ADD: begin
                w_alu_a = DATA_W'(r_worst);
                w_alu_b = DATA_W'(r_best);
            end
            S_WALK_CHK: begin
                w_alu_a = w_rentry.countdown;
                w_alu_b = DATA_W'(1);
            end
            S_WALK_REL: begin
                w_alu_a = w_rentry.period;
                w_alu_b = DATA_W'(1);
            end
            S_REP_MAX: begin
                w_alu_a = DATA_W'(w_rentry.max_t);
                w_alu_b = DATA_W'(r_meas);
            end
            S_REP_LO: begin
                w_alu_a = DATA_W'(r_meas);
                w_alu_b = DATA_W'(w_rentry.best);
            end
            S_REP_HI: begin
                w_alu_a = DATA_W'(w_rentry.worst);
                w_alu_b = DATA_W'(r_meas);
            end
            default: begin
                w_alu_a = '0;
                w_alu_b = '0;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_task_cnt = r_task_cnt;
        n_walk_pos = r_walk_pos;
        n_await    = r_await;
        n_halted   = r_halted;
        n_cont     = r_cont;
        n_period   = r_period;
        n_offset   = r_offset;
        n_best     = r_best;
        n_worst    = r_worst;
        n_meas     = r_meas;
        n_new_max  = r_new_max;
        n_fail     = r_fail;
        n_res      = r_res;
        w_we       = 1'b0;
        w_re       = 1'b0;
        w_waddr    = r_walk_pos[IDX_W-1:0];
        w_raddr    = r_walk_pos[IDX_W-1:0];
        w_wentry   = w_rentry;

        unique case (r_state)
            S_IDLE: begin
                if (w_s_acc) begin
                    n_res  = '0;
                    n_cont = 1'b0;
                    n_res.last_of_run = 1'b1;
                    if (r_halted) begin
                        n_res.kind = KIND_HALTED;
                        n_state    = S_EMIT;
                    end else if ((i_s_tuser == OP_ADD || i_s_tuser == OP_TICK) && r_await) begin
                        n_res.kind = KIND_BUSY;
                        n_state    = S_EMIT;
                    end else begin
                        case (i_s_tuser)
                            OP_ADD: begin
                                n_period = w_in_period;
                                n_offset = w_in_offset[SW-1:0];
                                n_best   = w_in_best[SW-1:0];
                                n_worst  = w_in_worst[SW-1:0];
                                n_state  = S_ADD;
                            end
                            OP_TICK: begin
                                n_walk_pos = '0;
                                n_state    = S_WALK_RD;
                            end
                            OP_REPORT: begin
                                // a report nobody waits for is dropped
                                if (r_await) begin
                                    n_meas  = w_in_meas[SW-1:0];
                                    n_state = S_REP_RD;
                                end
                            end
                            default: begin
                                n_state = S_IDLE;
                            end
                        endcase
                    end
                end
            end

            S_ADD: begin
                n_res = '0;
                n_res.kind        = KIND_ADD;
                n_res.last_of_run = 1'b1;
                n_cont            = 1'b0;
                // alu lt here means worst < best
                if (r_period != '0 && !w_full && !w_alu.lt) begin
                    w_we               = 1'b1;
                    w_waddr            = r_task_cnt[IDX_W-1:0];
                    w_wentry.period    = r_period;
                    w_wentry.countdown = r_period;
                    w_wentry.offset    = r_offset;
                    w_wentry.best      = r_best;
                    w_wentry.worst     = (r_worst != '0) ? r_worst : r_default_wc[SW-1:0];
                    w_wentry.last_t    = '0;
                    w_wentry.max_t     = '0;
                    n_task_cnt         = r_task_cnt + CNT_W'(1);
                    n_res.accepted     = 1'b1;
                    n_res.task_index   = TIDX_W'(r_task_cnt);
                end
                n_state = S_EMIT;
            end

            S_WALK_RD: begin
                if (r_walk_pos >= r_task_cnt) begin
                    n_res = '0;
                    n_res.kind        = KIND_DONE;
                    n_res.last_of_run = 1'b1;
                    n_cont            = 1'b0;
                    n_walk_pos        = '0;
                    n_state           = S_EMIT;
                end else begin
                    w_re    = 1'b1;
                    n_state = S_WALK_CHK;
                end
            end

            S_WALK_CHK: begin
                // countdown < 1 means the entry is due
                if (w_alu.lt) begin
                    n_state = S_WALK_REL;
                end else begin
                    w_we               = 1'b1;
                    w_wentry.countdown = w_alu.diff;
                    n_walk_pos         = r_walk_pos + CNT_W'(1);
                    n_state            = S_WALK_RD;
                end
            end

            S_WALK_REL: begin
                w_we               = 1'b1;
                w_wentry.countdown = w_alu.diff;
                n_await            = 1'b1;
                n_res = '0;
                n_res.kind         = KIND_RELEASE;
                n_res.task_index   = TIDX_W'(r_walk_pos);
                n_res.offset_wait  = DATA_W'(w_rentry.offset);
                n_res.last_of_run  = 1'b1;
                n_cont             = 1'b0;
                n_state            = S_EMIT;
            end

            S_REP_RD: begin
                w_re    = 1'b1;
                n_state = S_REP_MAX;
            end

            S_REP_MAX: begin
                n_new_max = w_alu.lt ? r_meas : w_rentry.max_t;
                n_state   = S_REP_LO;
            end

            S_REP_LO: begin
                n_fail  = w_alu.lt;
                n_state = S_REP_HI;
            end

            S_REP_HI: begin
                w_we            = 1'b1;
                w_wentry.last_t = r_meas;
                w_wentry.max_t  = r_new_max;
                n_await         = 1'b0;
                n_res = '0;
                n_res.kind        = KIND_REPORT;
                n_res.task_index  = TIDX_W'(r_walk_pos);
                n_res.last_exec   = DATA_W'(r_meas);
                n_res.worst_exec  = DATA_W'(r_new_max);
                if (r_fail || w_alu.lt) begin
                    n_halted          = 1'b1;
                    n_walk_pos        = '0;
                    n_res.last_of_run = 1'b1;
                    n_cont            = 1'b0;
                end else begin
                    n_res.accepted    = 1'b1;
                    n_walk_pos        = r_walk_pos + CNT_W'(1);
                    n_cont            = 1'b1;
                end
                n_state = S_EMIT;
            end

            S_EMIT: begin
                if (w_out_free) begin
                    n_state = r_cont ? S_WALK_RD : S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb begin
        n_ovalid = r_ovalid;
        n_out    = r_out;
        if (r_state == S_EMIT && w_out_free) begin
            n_ovalid = 1'b1;
            n_out    = r_res;
        end else if (i_m_tready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_task_cnt   <= '0;
            r_walk_pos   <= '0;
            r_await      <= 1'b0;
            r_halted     <= 1'b0;
            r_cont       <= 1'b0;
            r_ovalid     <= 1'b0;
            r_task_limit <= TASK_LIMIT_RST;
            r_default_wc <= DEFAULT_WC_RST;
        end else begin
            r_state    <= n_state;
            r_task_cnt <= n_task_cnt;
            r_walk_pos <= n_walk_pos;
            r_await    <= n_await;
            r_halted   <= n_halted;
            r_cont     <= n_cont;
            r_ovalid   <= n_ovalid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_TASK_LIMIT: r_task_limit <= i_cfg_data[LIMIT_W-1:0];
                    CFG_DEFAULT_WC: r_default_wc <= i_cfg_data;
                    default:        r_task_limit <= r_task_limit;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_period  <= n_period;
        r_offset  <= n_offset;
        r_best    <= n_best;
        r_worst   <= n_worst;
        r_meas    <= n_meas;
        r_new_max <= n_new_max;
        r_fail    <= n_fail;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_out.last_of_run;
    assign o_m_tdata  = {{OUT_PAD_W{1'b0}}, r_out.worst_exec, r_out.last_exec,
                         r_out.offset_wait, r_out.task_index, r_out.accepted};

    // Once halted, the block stays halted until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag cleared");

    // A pending report always points at a live table entry
    a_await_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_await |-> (r_walk_pos < r_task_cnt))
        else $error("awaited report points past table");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_task_cnt <= CNT_W'(MAX_TASKS))
        else $error("task count beyond table size");

    // A failed report answer is only shown once the halt has taken effect
    a_fail_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == KIND_REPORT && !o_m_tdata[0]) |-> r_halted)
        else $error("failed report without halt");

    // Only a passing report answer is followed by a second answer
    a_two_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> (o_m_tuser == KIND_REPORT && o_m_tdata[0]))
        else $error("unexpected non-final answer");

endmodule

`default_nettype wire
